[design/tta_pkg.sv]
// Shared constants and types for the tap tempo averager.
`timescale 1ns / 1ps
package tta_pkg;

    // History depth and the widths that follow from it.
    localparam int HISTORY_DEPTH = 4;
    localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    // Field widths.
    localparam int TIME_W     = 32;
    localparam int GAP_W      = 16;
    localparam int PERIOD_W   = 16;
    localparam int BEAT_W     = 12;
    localparam int TIMEOUT_W  = 16;
    localparam int MIN_IVL_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Sum of the history in ms, and the dividend in sixteenths of a ms.
    localparam int FRAC_W     = 4;
    localparam int SUM_W      = GAP_W + $clog2(HISTORY_DEPTH);
    localparam int DIVD_W     = SUM_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BEAT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BEAT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd3;

    // Reset values.
    localparam logic [BEAT_W-1:0]    MIN_BEAT_RST     = 12'd200;
    localparam logic [BEAT_W-1:0]    MAX_BEAT_RST     = 12'd1500;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 16'd3000;
    localparam logic [MIN_IVL_W-1:0] MIN_INTERVAL_RST = 10'd50;
    localparam logic [PERIOD_W-1:0]  PERIOD_RST       = 16'd8000;

    // Input function codes.
    localparam logic FUNC_TAP  = 1'b0;
    localparam logic FUNC_HOLD = 1'b1;

    // Control from the sequencer to the interval history.
    typedef struct packed {
        logic clear;
        logic push;
    } hist_ctrl_t;

endpackage

[design/tta_hist.sv]
// Interval history: a short shift line of tap gaps with its fill count.
`timescale 1ns / 1ps
module tta_hist
    import tta_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hist_ctrl_t            ctrl,
    input  logic [GAP_W-1:0]      gap,
    input  logic [HIST_IDX_W-1:0] rd_idx,
    output logic [GAP_W-1:0]      rd_data,
    output logic [CNT_W-1:0]      count
);

    logic [GAP_W-1:0] entry_reg [HISTORY_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Fill count: cleared on restart, grows on push until full.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.push && (count_reg < CNT_W'(HISTORY_DEPTH)))
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Entries: append while filling, otherwise drop the oldest and append.
    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.clear)
        begin
            if (count_reg < CNT_W'(HISTORY_DEPTH))
            begin
                entry_reg[count_reg[HIST_IDX_W-1:0]] <= gap;
            end
            else
            begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                begin
                    entry_reg[i] <= entry_reg[i + 1];
                end
                entry_reg[HISTORY_DEPTH - 1] <= gap;
            end
        end
    end

    assign rd_data = entry_reg[rd_idx];
    assign count   = count_reg;

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("history count beyond depth");

endmodule

[design/tta_div.sv]
// Restoring divider, one quotient bit per cycle, for the mean of the history.
`timescale 1ns / 1ps
module tta_div
    import tta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dsor_reg;
    logic [DIVD_W-1:0]    quot_reg;

    logic [CNT_W:0]       trial;
    logic                 fits;
    logic [CNT_W:0]       diff;

    // One trial subtraction per cycle.
    always_comb
    begin
        trial = {rem_reg, quot_reg[DIVD_W-1]};
        fits  = (trial >= {1'b0, dsor_reg});
        diff  = trial - {1'b0, dsor_reg};
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= DIV_CNT_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - DIV_CNT_W'(1);
                if (step_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            dsor_reg <= divisor;
            quot_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quot_reg <= {quot_reg[DIVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    // A result only follows a running division.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

[design/tap_tempo_averager_unit.sv]
// Tap tempo averager top level: sequencer, tap timing, clamp and result register.
`timescale 1ns / 1ps
// Each transaction on the input is a tap press or a long hold and gives exactly one
// result transaction. The block takes one item at a time and raises in_stall while it
// works. A long hold or a first tap is evaluated and goes straight to the result; a timeout
// or bounce tap is classified first. A tap that updates the tempo sums the history one stored
// interval at a time, then runs a divider that produces one quotient bit per cycle over the
// 22-bit dividend, then the clamp. A finished result sits in the output register, so
// the next item can be taken while the downstream side stalls. The configuration port
// is always ready; registers are meant to be written only while the block is idle.
module tap_tempo_averager_unit
    import tta_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input items.
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [TIME_W-1:0]     now_ms,
    // Result items.
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PERIOD_W-1:0]   tempo_sixteenths,
    output logic                  sweeping,
    output logic                  tempo_updated
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EVAL  = 8'b0000_0010,
        S_CLASS = 8'b0000_0100,
        S_SUM   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_CLAMP = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } state_t;

    state_t               state_reg;
    state_t               state_next;

    // Configuration registers.
    logic [BEAT_W-1:0]    min_beat_reg;
    logic [BEAT_W-1:0]    max_beat_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [MIN_IVL_W-1:0] min_ivl_reg;

    // Tempo state.
    logic                 awaiting_reg;
    logic                 awaiting_next;
    logic [TIME_W-1:0]    last_tap_reg;
    logic [TIME_W-1:0]    last_tap_next;
    logic [PERIOD_W-1:0]  period_reg;
    logic [PERIOD_W-1:0]  period_next;
    logic                 sweep_reg;
    logic                 sweep_next;
    logic                 updated_reg;
    logic                 updated_next;

    // Item under work.
    logic                 func_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    gap_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [CNT_W-1:0]     sum_idx_reg;
    logic [CNT_W-1:0]     sum_idx_next;

    // Output register.
    logic                 out_valid_reg;
    logic [PERIOD_W-1:0]  out_tempo_reg;
    logic                 out_sweep_reg;
    logic                 out_updated_reg;
    logic                 out_load;

    // Unit links.
    hist_ctrl_t           hist_ctrl;
    logic [GAP_W-1:0]     hist_rd_data;
    logic [CNT_W-1:0]     hist_count;
    logic                 div_start;
    logic                 div_done;
    logic [DIVD_W-1:0]    div_quot;

    logic                 in_accept;
    logic                 gap_timeout;
    logic                 gap_bounce;
    logic [DIVD_W-1:0]    lo_limit;
    logic [DIVD_W-1:0]    hi_limit;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    tta_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (hist_ctrl),
        .gap     (gap_reg[GAP_W-1:0]),
        .rd_idx  (sum_idx_reg[HIST_IDX_W-1:0]),
        .rd_data (hist_rd_data),
        .count   (hist_count)
    );

    tta_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_next, FRAC_W'(0)}),
        .divisor  (hist_count),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_beat_reg <= MIN_BEAT_RST;
            max_beat_reg <= MAX_BEAT_RST;
            timeout_reg  <= TIMEOUT_RST;
            min_ivl_reg  <= MIN_INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_BEAT:     min_beat_reg <= cfg_data[BEAT_W-1:0];
                REG_MAX_BEAT:     max_beat_reg <= cfg_data[BEAT_W-1:0];
                REG_TIMEOUT:      timeout_reg  <= cfg_data[TIMEOUT_W-1:0];
                REG_MIN_INTERVAL: min_ivl_reg  <= cfg_data[MIN_IVL_W-1:0];
                default:          min_beat_reg <= min_beat_reg;
            endcase
        end
    end

    // Gap classification and clamp limits.
    always_comb
    begin
        gap_timeout = (gap_reg > TIME_W'(timeout_reg));
        gap_bounce  = (gap_reg <= TIME_W'(min_ivl_reg));
        lo_limit    = DIVD_W'({min_beat_reg, FRAC_W'(0)});
        hi_limit    = DIVD_W'({max_beat_reg, FRAC_W'(0)});
        sum_next    = sum_reg + SUM_W'(hist_rd_data);
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        awaiting_next = awaiting_reg;
        last_tap_next = last_tap_reg;
        period_next   = period_reg;
        sweep_next    = sweep_reg;
        updated_next  = updated_reg;
        sum_idx_next  = sum_idx_reg;
        hist_ctrl     = '0;
        div_start     = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                updated_next = 1'b0;
                if (func_reg == FUNC_HOLD)
                begin
                    sweep_next      = 1'b0;
                    awaiting_next   = 1'b1;
                    hist_ctrl.clear = 1'b1;
                    state_next      = S_DONE;
                end
                else if (awaiting_reg)
                begin
                    awaiting_next   = 1'b0;
                    hist_ctrl.clear = 1'b1;
                    last_tap_next   = now_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (gap_timeout)
                begin
                    hist_ctrl.clear = 1'b1;
                    last_tap_next   = now_reg;
                    state_next      = S_DONE;
                end
                else if (gap_bounce)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    hist_ctrl.push = 1'b1;
                    last_tap_next  = now_reg;
                    sweep_next     = 1'b1;
                    sum_idx_next   = '0;
                    state_next     = S_SUM;
                end
            end
            S_SUM:
            begin
                // One history entry per cycle; the last one starts the divider.
                sum_idx_next = sum_idx_reg + CNT_W'(1);
                if (sum_idx_next == hist_count)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                priority if (div_quot < lo_limit)
                begin
                    period_next = lo_limit[PERIOD_W-1:0];
                end
                else if (div_quot > hi_limit)
                begin
                    period_next = hi_limit[PERIOD_W-1:0];
                end
                else
                begin
                    period_next = div_quot[PERIOD_W-1:0];
                end
                updated_next = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            awaiting_reg  <= 1'b1;
            last_tap_reg  <= '0;
            period_reg    <= PERIOD_RST;
            sweep_reg     <= 1'b0;
            updated_reg   <= 1'b0;
            sum_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            awaiting_reg <= awaiting_next;
            last_tap_reg <= last_tap_next;
            period_reg   <= period_next;
            sweep_reg    <= sweep_next;
            updated_reg  <= updated_next;
            sum_idx_reg  <= sum_idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= func;
            now_reg  <= now_ms;
        end
        if (state_reg == S_EVAL)
        begin
            gap_reg <= now_reg - last_tap_reg;
        end
        if (state_reg == S_CLASS)
        begin
            sum_reg <= '0;
        end
        else if (state_reg == S_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (out_load)
        begin
            out_tempo_reg   <= period_reg;
            out_sweep_reg   <= sweep_reg;
            out_updated_reg <= updated_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign tempo_sixteenths = out_tempo_reg;
    assign sweeping         = out_sweep_reg;
    assign tempo_updated    = out_updated_reg;

    // A new tempo always comes with the sweep running.
    a_updated_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_updated_reg || out_sweep_reg))
        else $error("tempo update reported without sweep");

    // Summing only runs over a non-empty history.
    a_sum_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> (hist_count != '0))
        else $error("summing an empty history");

    // An accepted item keeps the input side stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input taken again right after an accept");

endmodule
